[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off while reset is active.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion sampled on the rising clock edge that also holds while reset is active.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/ggef_pkg.sv]
// Shared types and constants of the gray gradient edge filter.
`default_nettype none

package ggef_pkg;

    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_WIDTH_W = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 1'b1;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd512;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_HORIZONTAL = 2'd0,
        MODE_VERTICAL = 2'd1,
        MODE_EUCLIDEAN = 2'd2,
        MODE_SUM = 2'd3
    } gradient_mode_t;

    localparam gradient_mode_t GRADIENT_MODE_RESET = MODE_SUM;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_ROOT = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [7:0] ax;
        logic [7:0] ay;
        logic [7:0] alpha;
    } grad_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

[hdl/ggef_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module ggef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write of the same address on one edge return the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/ggef_front.sv]
// Front end: pixel intake, gray conversion, raster position and neighbor differences.
`default_nettype none

module ggef_front #(
    parameter int MAX_WIDTH = ggef_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  logic [7:0]                       red,
    input  logic [7:0]                       green,
    input  logic [7:0]                       blue,
    input  logic [7:0]                       alpha,
    input  logic                             frame_start,
    input  logic [ggef_pkg::ROW_WIDTH_W-1:0] row_width,
    input  ggef_pkg::queue_status_t          q_status,
    output logic                             push,
    output ggef_pkg::grad_entry_t            push_entry
);

    import ggef_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic [7:0]       left_gray_reg;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [7:0]       s1_gray_reg;
    logic [8:0]       s1_dx_reg;
    logic             s1_first_row_reg;
    logic [7:0]       s1_alpha_reg;

    logic             accept;
    logic [WID_W-1:0] width_eff;
    logic [COL_W-1:0] col_eff;
    logic             first_row_eff;
    logic [WID_W-1:0] col_inc;
    logic             row_end;
    logic [12:0]      gray_sum;
    logic [7:0]       gray;
    logic [8:0]       dx;
    logic [8:0]       dy;
    logic [7:0]       above_gray;

    assign pixel_stall = s1_valid_reg && q_status.full;
    assign accept = pixel_valid && !pixel_stall;
    assign push = s1_valid_reg && !q_status.full;

    always_comb
    begin
        priority if (row_width == '0)
        begin
            width_eff = WID_W'(1);
        end
        else if (32'(row_width) > 32'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WID_W'(row_width);
        end
    end

    assign col_eff = frame_start ? '0 : col_reg;
    assign first_row_eff = frame_start || first_row_reg;
    assign col_inc = WID_W'(col_eff) + WID_W'(1);
    assign row_end = col_inc >= width_eff;
    assign col_next = row_end ? '0 : COL_W'(col_inc);
    assign first_row_next = row_end ? 1'b0 : first_row_eff;

    assign gray_sum = 13'(red) * 13'd11 + 13'(green) * 13'd16 + 13'(blue) * 13'd5;
    assign gray = gray_sum[12:5];
    assign dx = {1'b0, gray} - ((col_eff != '0) ? {1'b0, left_gray_reg} : 9'd0);

    ggef_ram #(
        .WIDTH(8),
        .DEPTH(MAX_WIDTH)
    ) u_row_store (
        .clk  (clk),
        .we   (accept),
        .waddr(col_eff),
        .wdata(gray),
        .re   (accept),
        .raddr(col_eff),
        .rdata(above_gray)
    );

    always_comb
    begin
        priority if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            first_row_reg <= 1'b1;
            left_gray_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg <= col_next;
                first_row_reg <= first_row_next;
                left_gray_reg <= gray;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_gray_reg <= gray;
            s1_dx_reg <= dx;
            s1_first_row_reg <= first_row_eff;
            s1_alpha_reg <= alpha;
        end
    end

    assign dy = {1'b0, s1_gray_reg} - (s1_first_row_reg ? 9'd0 : {1'b0, above_gray});

    always_comb
    begin
        push_entry.ax = s1_dx_reg[8] ? 8'(-s1_dx_reg) : s1_dx_reg[7:0];
        push_entry.ay = dy[8] ? 8'(-dy) : dy[7:0];
        push_entry.alpha = s1_alpha_reg;
    end

endmodule

`default_nettype wire

[hdl/ggef_queue.sv]
// Short FIFO of gradient magnitudes between the front end and the back end.
`default_nettype none

module ggef_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ggef_pkg::grad_entry_t   push_entry,
    input  logic                    pop,
    output ggef_pkg::grad_entry_t   pop_entry,
    output ggef_pkg::queue_status_t status
);

    import ggef_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    grad_entry_t      entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign status.full = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:
            begin
                count_next = count_reg + (PTR_W + 1)'(1);
            end
            2'b01:
            begin
                count_next = count_reg - (PTR_W + 1)'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[hdl/ggef_back.sv]
// Back end: gradient selection, iterative square root, clamping and the result register.
`default_nettype none

module ggef_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ggef_pkg::gradient_mode_t gradient_mode,
    input  ggef_pkg::queue_status_t  q_status,
    input  ggef_pkg::grad_entry_t    pop_entry,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [7:0]               edge_level,
    output logic [7:0]               alpha_out
);

    import ggef_pkg::*;

    localparam logic [16:0] ROOT_BIT_START = 17'h10000;

    back_state_t state_reg;
    back_state_t state_next;

    logic [16:0] n_reg;
    logic [16:0] root_reg;
    logic [16:0] bit_reg;
    logic [7:0]  alpha_hold_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  level_reg;
    logic [7:0]  alpha_out_reg;

    logic        out_free;
    logic        last_step;
    logic        load_root;
    logic        emit_direct;
    logic        emit_root;
    logic        root_step_en;
    logic [16:0] square_sum;
    logic [17:0] trial;
    logic        take;
    logic [16:0] n_step;
    logic [16:0] root_step;
    logic [8:0]  abs_sum;
    logic [7:0]  direct_level;
    logic [7:0]  root_level;

    assign out_free = !out_valid_reg || !result_stall;
    assign last_step = bit_reg[0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_status.empty && out_free && gradient_mode == MODE_EUCLIDEAN)
                begin
                    state_next = BACK_ROOT;
                end
            end
            BACK_ROOT:
            begin
                if (last_step && out_free)
                begin
                    state_next = BACK_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        load_root = 1'b0;
        emit_direct = 1'b0;
        emit_root = 1'b0;
        root_step_en = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                pop = !q_status.empty && out_free;
                load_root = pop && gradient_mode == MODE_EUCLIDEAN;
                emit_direct = pop && gradient_mode != MODE_EUCLIDEAN;
            end
            BACK_ROOT:
            begin
                root_step_en = !last_step || out_free;
                emit_root = last_step && out_free;
            end
        endcase
    end

    assign square_sum = 17'(16'(pop_entry.ax) * 16'(pop_entry.ax))
                      + 17'(16'(pop_entry.ay) * 16'(pop_entry.ay));

    assign trial = 18'(root_reg) + 18'(bit_reg);
    assign take = 18'(n_reg) >= trial;
    assign n_step = take ? (n_reg - trial[16:0]) : n_reg;
    assign root_step = take ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign root_level = (root_step[16:8] != '0) ? LEVEL_MAX : root_step[7:0];

    assign abs_sum = 9'(pop_entry.ax) + 9'(pop_entry.ay);

    always_comb
    begin
        unique case (gradient_mode)
            MODE_HORIZONTAL:
            begin
                direct_level = pop_entry.ax;
            end
            MODE_VERTICAL:
            begin
                direct_level = pop_entry.ay;
            end
            MODE_EUCLIDEAN:
            begin
                direct_level = '0;
            end
            MODE_SUM:
            begin
                direct_level = abs_sum[8] ? LEVEL_MAX : abs_sum[7:0];
            end
        endcase
    end

    always_comb
    begin
        priority if (emit_direct || emit_root)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_root)
        begin
            n_reg <= square_sum;
            root_reg <= '0;
            bit_reg <= ROOT_BIT_START;
            alpha_hold_reg <= pop_entry.alpha;
        end
        else if (root_step_en)
        begin
            n_reg <= n_step;
            root_reg <= root_step;
            bit_reg <= bit_reg >> 2;
        end
        if (emit_direct)
        begin
            level_reg <= direct_level;
            alpha_out_reg <= pop_entry.alpha;
        end
        else if (emit_root)
        begin
            level_reg <= root_level;
            alpha_out_reg <= alpha_hold_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign edge_level = level_reg;
    assign alpha_out = alpha_out_reg;

endmodule

`default_nettype wire

[hdl/gray_gradient_edge_filter_core.sv]
// Top level of the gray gradient edge filter: configuration registers and the two halves.
`default_nettype none

// The filter takes one RGB pixel per transfer in raster order and returns one edge level
// with the pixel's alpha. In the horizontal, vertical and sum modes it sustains one pixel
// per cycle while the result side is not stalled; in the Euclidean mode the back end takes
// no new pixel until the nine-step square root unit that it iterates has finished the
// current one. A pixel's result passes the front end's stage register, the queue and the
// result register; in the Euclidean mode it also passes the square root unit's registers.
// A four-entry queue separates the front end, which owns the line store, from the back
// end, so either side can stall alone. The line store needs no clearing after reset, and
// configuration writes are meant for idle periods between frames.

module gray_gradient_edge_filter_core #(
    parameter int MAX_WIDTH = ggef_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  logic [7:0]                       red,
    input  logic [7:0]                       green,
    input  logic [7:0]                       blue,
    input  logic [7:0]                       alpha,
    input  logic                             frame_start,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [7:0]                       edge_level,
    output logic [7:0]                       alpha_out,
    input  logic                             wr_en,
    input  logic [ggef_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [ggef_pkg::CFG_DATA_W-1:0]  wr_data
);

    import ggef_pkg::*;

    gradient_mode_t         mode_reg;
    logic [ROW_WIDTH_W-1:0] row_width_reg;

    logic          push;
    logic          pop;
    grad_entry_t   push_entry;
    grad_entry_t   pop_entry;
    queue_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= GRADIENT_MODE_RESET;
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_GRADIENT_MODE:
                begin
                    mode_reg <= gradient_mode_t'(wr_data[1:0]);
                end
                REG_ROW_WIDTH:
                begin
                    row_width_reg <= wr_data[ROW_WIDTH_W-1:0];
                end
            endcase
        end
    end

    ggef_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .frame_start(frame_start),
        .row_width  (row_width_reg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    ggef_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .pop_entry (pop_entry),
        .status    (q_status)
    );

    ggef_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gradient_mode(mode_reg),
        .q_status     (q_status),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .edge_level   (edge_level),
        .alpha_out    (alpha_out)
    );

endmodule

`default_nettype wire

[hdl/ggef_checker.sv]
// Port-level assertions for the gray gradient edge filter and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module ggef_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             pixel_valid,
    input wire logic                             pixel_stall,
    input wire logic [7:0]                       red,
    input wire logic [7:0]                       green,
    input wire logic [7:0]                       blue,
    input wire logic [7:0]                       alpha,
    input wire logic                             frame_start,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire logic [7:0]                       edge_level,
    input wire logic [7:0]                       alpha_out,
    input wire logic                             wr_en,
    input wire logic [ggef_pkg::CFG_INDEX_W-1:0] wr_index,
    input wire logic [ggef_pkg::CFG_DATA_W-1:0]  wr_data
);

    // A stalled result keeps its valid and its payload.
    `ASSERT_CLK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(edge_level) && $stable(alpha_out), "stalled result changed")

    // The front end can only start stalling right after it took a pixel.
    `ASSERT_CLK(a_stall_after_transfer, $rose(pixel_stall) |-> $past(pixel_valid && !pixel_stall), "pixel stall rose without a transfer")

    // Reset leaves no result pending and the pixel side open.
    `ASSERT_CLK_ALWAYS(a_reset_idle, !rst_n |=> !result_valid && !pixel_stall, "block not idle after reset")

endmodule

bind gray_gradient_edge_filter_core ggef_checker u_checker (.*);

`default_nettype wire
